// ----- rtl/far_pkg.sv -----
package far_pkg;

	localparam int FIELD_BITS = 16;

	typedef enum logic [1:0] {
		FORM_WHOLE  = 2'd0,
		FORM_MIXED  = 2'd1,
		FORM_PROPER = 2'd2,
		FORM_ERROR  = 2'd3
	} form_t;

	// input word: two fractions
	typedef struct packed {
		logic [FIELD_BITS-1:0] first_numerator;
		logic [FIELD_BITS-1:0] first_denominator;
		logic [FIELD_BITS-1:0] second_numerator;
		logic [FIELD_BITS-1:0] second_denominator;
	} operands_t;

	// result word: reduced sum
	typedef struct packed {
		logic [2*FIELD_BITS:0]   integer_part;
		logic [2*FIELD_BITS:0]   remainder_numerator;
		logic [2*FIELD_BITS-1:0] reduced_denominator;
		form_t                   result_form;
	} result_t;

	// divider request from the sequencer
	typedef struct packed {
		logic start;
	} div_ctl_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- rtl/far_div.sv -----
module far_div #(
	parameter int W = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  far_pkg::div_ctl_t ctl,
	input  logic [W-1:0]      dividend,
	input  logic [W-1:0]      divisor,
	output far_pkg::div_sts_t sts,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/fraction_add_reduce.sv -----
// fraction_add_reduce: adds two unsigned fractions a/b + c/d, reduces the sum
// by its greatest common divisor and splits it into integer part and remainder.
// in channel: in_valid/in_stall carry one operands word of four fraction fields.
// out channel: out_valid/out_stall carry one result word (integer part,
// remainder numerator, reduced denominator, form code).
// one word is in work at a time; in_stall is high from acceptance until
// the result has been taken.
// all divisions after the sum run on one shared restoring divider:
// one pass per Euclid step of the gcd, then three more passes for
// numerator / gcd, denominator / gcd and numerator / denominator.
// the next word is taken only after the result has left.
// a zero denominator skips the divider: out_valid is set on the accepting edge.
// the result is held in an output register while out_stall is high.
// reset clears the sequencer and this module's datapath registers and drops out_valid.
module fraction_add_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  far_pkg::operands_t  operands,
	output logic                out_valid,
	input  logic                out_stall,
	output far_pkg::result_t    result
);

	localparam int PW = 2 * far_pkg::FIELD_BITS;
	localparam int W  = PW + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SUM, ST_GCD, ST_DIVN, ST_DIVD, ST_SPLIT, ST_OUT
	} state_t;

	state_t state_q;
	logic [PW-1:0] p1_q, p2_q, den_q;
	logic [W-1:0]  num_q, x_q, y_q, g_q;
	logic [W-1:0]  div_a, div_b, quo, rem;
	logic          wait_q;
	far_pkg::div_ctl_t dctl;
	far_pkg::div_sts_t dsts;

	logic [W-1:0]  whole_q, remn_q;
	logic [PW-1:0] rden_q;
	far_pkg::form_t form_q;

	far_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl),
		.dividend(div_a), .divisor(div_b),
		.sts(dsts), .quotient(quo), .remainder(rem)
	);

	always_comb begin
		div_a = x_q;
		div_b = y_q;
		unique case (state_q)
			ST_DIVN:  begin div_a = num_q;            div_b = g_q; end
			ST_DIVD:  begin div_a = {1'b0, den_q};    div_b = g_q; end
			ST_SPLIT: begin div_a = num_q;            div_b = {1'b0, den_q}; end
			default:  begin div_a = x_q;              div_b = y_q; end
		endcase
	end

	assign dctl.start = !wait_q && !dsts.busy &&
		((state_q == ST_GCD && y_q != '0) || state_q == ST_DIVN ||
		state_q == ST_DIVD || state_q == ST_SPLIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
			p1_q      <= '0;
			p2_q      <= '0;
			den_q     <= '0;
			num_q     <= '0;
			x_q       <= '0;
			y_q       <= '0;
			g_q       <= '0;
			whole_q   <= '0;
			remn_q    <= '0;
			rden_q    <= '0;
			form_q    <= far_pkg::FORM_WHOLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (operands.first_denominator == '0 ||
								operands.second_denominator == '0) begin
							whole_q   <= '0;
							remn_q    <= '0;
							rden_q    <= '0;
							form_q    <= far_pkg::FORM_ERROR;
							out_valid <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							p1_q    <= PW'(operands.first_numerator) *
								PW'(operands.second_denominator);
							p2_q    <= PW'(operands.second_numerator) *
								PW'(operands.first_denominator);
							den_q   <= PW'(operands.first_denominator) *
								PW'(operands.second_denominator);
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					num_q   <= W'(p1_q) + W'(p2_q);
					x_q     <= W'(p1_q) + W'(p2_q);
					y_q     <= W'(den_q);
					wait_q  <= 1'b0;
					state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (!wait_q) begin
						if (y_q == '0) begin
							g_q     <= x_q;
							state_q <= ST_DIVN;
						end else begin
							wait_q <= 1'b1;
						end
					end else if (dsts.done) begin
						x_q    <= y_q;
						y_q    <= rem;
						wait_q <= 1'b0;
					end
				end
				ST_DIVN: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (dsts.done) begin
						num_q   <= quo;
						wait_q  <= 1'b0;
						state_q <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (dsts.done) begin
						den_q   <= quo[PW-1:0];
						wait_q  <= 1'b0;
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (dsts.done) begin
						wait_q    <= 1'b0;
						rden_q    <= den_q;
						whole_q   <= quo;
						remn_q    <= rem;
						if (num_q < W'(den_q)) begin
							form_q <= far_pkg::FORM_PROPER;
						end else if (rem == '0) begin
							form_q <= far_pkg::FORM_WHOLE;
						end else begin
							form_q <= far_pkg::FORM_MIXED;
						end
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign result   = '{integer_part: whole_q, remainder_numerator: remn_q,
		reduced_denominator: rden_q, result_form: form_q};

endmodule

// ----- rtl/far_checker.sv -----
module far_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input far_pkg::result_t result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("stalled result word changed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after accept");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result.result_form == far_pkg::FORM_ERROR |->
		result.integer_part == '0 && result.remainder_numerator == '0 &&
		result.reduced_denominator == '0)
		else $error("error word not cleared");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result.result_form != far_pkg::FORM_ERROR |->
		result.reduced_denominator != '0)
		else $error("zero reduced denominator");

endmodule

bind fraction_add_reduce far_checker u_far_checker (.*);

// ----- tb/sv/fraction_add_reduce_tb.sv -----
module fraction_add_reduce_tb;

	localparam int FB = far_pkg::FIELD_BITS;
	localparam int RANDOM_WORDS = 1250;

	typedef far_pkg::operands_t operands_t;
	typedef far_pkg::result_t   sum_t;

	typedef struct packed {
		operands_t op;
		logic      typed;
		sum_t      res;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	operands_t op_drv;
	sum_t res_mon;

	sum_t pending_sums[$];
	int errors;
	int taken;

	fraction_add_reduce dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operands(op_drv),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(res_mon)
	);

	function automatic sum_t reduce_sum(operands_t op);
		sum_t s;
		longint unsigned num, den, x, y, r, q;
		s = '0;
		if (op.first_denominator == 0 || op.second_denominator == 0) begin
			s.result_form = far_pkg::FORM_ERROR;
			return s;
		end
		num = longint'(op.first_numerator) * op.second_denominator +
			longint'(op.second_numerator) * op.first_denominator;
		den = longint'(op.first_denominator) * op.second_denominator;
		x = num;
		y = den;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		num = num / x;
		den = den / x;
		s.reduced_denominator = den[2*FB-1:0];
		if (num >= den) begin
			q = num / den;
			r = num % den;
			s.integer_part = q[2*FB:0];
			s.remainder_numerator = r[2*FB:0];
			s.result_form = (r == 0) ? far_pkg::FORM_WHOLE : far_pkg::FORM_MIXED;
		end else begin
			s.remainder_numerator = num[2*FB:0];
			s.result_form = far_pkg::FORM_PROPER;
		end
		return s;
	endfunction

	function automatic row_t mk(int n1, int d1, int n2, int d2, bit typed,
			longint w, longint rm, longint dn, far_pkg::form_t f);
		row_t r;
		r.op = '{n1[FB-1:0], d1[FB-1:0], n2[FB-1:0], d2[FB-1:0]};
		r.typed = typed;
		r.res = '{w[2*FB:0], rm[2*FB:0], dn[2*FB-1:0], f};
		return r;
	endfunction

	function automatic logic [FB-1:0] pick_field(bit is_den);
		int k;
		k = $urandom_range(0, 99);
		if (is_den && k < 4) return '0;
		if (k < 40) return FB'($urandom);
		if (k < 70) return FB'($urandom_range(1, 16));
		if (k < 80) return FB'({FB{1'b1}} - $urandom_range(0, 3));
		if (k < 90) return FB'(1 << $urandom_range(0, FB-1));
		return FB'($urandom_range(0, 300));
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#300000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_word(operands_t op, bit typed, sum_t res);
		int gap;
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		op_drv = op;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		pending_sums.push_back(typed ? res : reduce_sum(op));
		@(negedge clk);
	endtask

	initial begin
		row_t rows[$];
		operands_t op;
		int i;
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		op_drv = '0;
		errors = 0;
		taken = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		rows.push_back(mk(0, 1, 0, 1, 1, 0, 0, 1, far_pkg::FORM_PROPER));
		rows.push_back(mk(1, 0, 1, 1, 1, 0, 0, 0, far_pkg::FORM_ERROR));
		rows.push_back(mk(5, 3, 7, 0, 1, 0, 0, 0, far_pkg::FORM_ERROR));
		rows.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0, far_pkg::FORM_ERROR));
		rows.push_back(mk(65535, 0, 65535, 0, 1, 0, 0, 0, far_pkg::FORM_ERROR));
		rows.push_back(mk(65535, 1, 65535, 1, 1, 131070, 0, 1, far_pkg::FORM_WHOLE));
		rows.push_back(mk(65535, 65535, 65535, 65535, 1, 2, 0, 1, far_pkg::FORM_WHOLE));
		rows.push_back(mk(0, 65535, 0, 7, 1, 0, 0, 1, far_pkg::FORM_PROPER));
		rows.push_back(mk(1, 65535, 1, 65535, 1, 0, 2, 65535, far_pkg::FORM_PROPER));
		rows.push_back(mk(1, 2, 1, 3, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(3, 2, 1, 4, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(1, 2, 1, 2, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(65535, 65534, 65534, 65535, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(1, 65535, 1, 65534, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(65535, 2, 0, 65535, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(46368, 28657, 28657, 17711, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(21845, 43690, 43690, 21845, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		rows.push_back(mk(32768, 32768, 1, 32768, 0, 0, 0, 0, far_pkg::FORM_WHOLE));
		foreach (rows[k]) send_word(rows[k].op, rows[k].typed, rows[k].res);
		for (i = 0; i < RANDOM_WORDS; i++) begin
			op.first_numerator = pick_field(0);
			op.first_denominator = pick_field(1);
			op.second_numerator = pick_field(0);
			op.second_denominator = ($urandom_range(0, 9) == 0) ? op.first_denominator
				: pick_field(1);
			if (i == 600) begin
				in_valid = 0;
				while (pending_sums.size() != 0) @(negedge clk);
			end
			send_word(op, 0, '0);
		end
		in_valid = 0;
		while (pending_sums.size() != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// receiver stall pattern, one long hold-off partway through
	initial begin
		int run;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && taken >= 300) begin
				held = 1;
				out_stall = 1;
				for (run = 0; run < 4000; run++) @(negedge clk);
			end
			if ($urandom_range(0, 2) == 0) begin
				out_stall = 0;
				run = $urandom_range(5, 400);
			end else begin
				out_stall = 1'($urandom_range(0, 1));
				run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 3);
			end
			repeat (run) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		sum_t exp_sum;
		if (arst_n && out_valid && !out_stall) begin
			taken++;
			if (pending_sums.size() == 0) begin
				$display("%0t unexpected word: actual %h", $time, res_mon);
				errors++;
			end else begin
				exp_sum = pending_sums.pop_front();
				if (res_mon.integer_part !== exp_sum.integer_part) begin
					$display("%0t integer_part: expected %0d actual %0d",
						$time, exp_sum.integer_part, res_mon.integer_part);
					errors++;
				end
				if (res_mon.remainder_numerator !== exp_sum.remainder_numerator) begin
					$display("%0t remainder_numerator: expected %0d actual %0d",
						$time, exp_sum.remainder_numerator, res_mon.remainder_numerator);
					errors++;
				end
				if (res_mon.reduced_denominator !== exp_sum.reduced_denominator) begin
					$display("%0t reduced_denominator: expected %0d actual %0d",
						$time, exp_sum.reduced_denominator, res_mon.reduced_denominator);
					errors++;
				end
				if (res_mon.result_form !== exp_sum.result_form) begin
					$display("%0t result_form: expected %0d actual %0d",
						$time, exp_sum.result_form, res_mon.result_form);
					errors++;
				end
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/far_pkg.sv
rtl/far_div.sv
rtl/fraction_add_reduce.sv
rtl/far_checker.sv
tb/sv/fraction_add_reduce_tb.sv
